// File: hdl/dpmd_pkg.sv
package dpmd_pkg;

  typedef struct packed {
    logic [3:0]  kind;
    logic [5:0]  regs;
    logic [1:0]  space;
    logic [23:0] value;
  } operand_t;

  typedef struct packed {
    logic [1:0] opcode_class;
    logic       status;
    logic [1:0] words_used;
    operand_t   main_a;
    operand_t   main_b;
    operand_t   m00;
    operand_t   m01;
    operand_t   m10;
    operand_t   m11;
  } result_t;

  localparam logic [1:0] CLS_INVALID = 2'd0;
  localparam logic [1:0] CLS_ADC     = 2'd1;
  localparam logic [1:0] CLS_ABS     = 2'd2;

  localparam logic [1:0] WC_ONE = 2'd1;
  localparam logic [1:0] WC_TWO = 2'd2;

  localparam logic [7:0] OP_ADC0 = 8'h21;
  localparam logic [7:0] OP_ADC1 = 8'h29;
  localparam logic [7:0] OP_ADC2 = 8'h31;
  localparam logic [7:0] OP_ADC3 = 8'h39;
  localparam logic [7:0] OP_ABS0 = 8'h26;
  localparam logic [7:0] OP_ABS1 = 8'h2E;

  localparam logic [3:0] T_NONE   = 4'd0;
  localparam logic [3:0] T_REG    = 4'd1;
  localparam logic [3:0] T_SIMM   = 4'd2;
  localparam logic [3:0] T_PDECN  = 4'd3;
  localparam logic [3:0] T_PINCN  = 4'd4;
  localparam logic [3:0] T_PDEC   = 4'd5;
  localparam logic [3:0] T_PINC   = 4'd6;
  localparam logic [3:0] T_IDXN   = 4'd7;
  localparam logic [3:0] T_NOUPD  = 4'd8;
  localparam logic [3:0] T_PREDEC = 4'd9;
  localparam logic [3:0] T_ABS    = 4'd10;
  localparam logic [3:0] T_IMM    = 4'd11;

  localparam logic [5:0] RG_NONE = 6'd0;
  localparam logic [5:0] RG_X0   = 6'd1;
  localparam logic [5:0] RG_X1   = 6'd2;
  localparam logic [5:0] RG_Y0   = 6'd3;
  localparam logic [5:0] RG_Y1   = 6'd4;
  localparam logic [5:0] RG_A    = 6'd11;
  localparam logic [5:0] RG_B    = 6'd12;
  localparam logic [5:0] RG_R0   = 6'd13;
  localparam logic [5:0] RG_X    = 6'd29;
  localparam logic [5:0] RG_Y    = 6'd30;

  localparam logic [1:0] SP_NONE = 2'd0;
  localparam logic [1:0] SP_X    = 2'd1;
  localparam logic [1:0] SP_Y    = 2'd2;

  localparam logic [2:0] MODE_SPECIAL = 3'd6;
  localparam logic [2:0] RRR_ABS      = 3'd0;
  localparam logic [2:0] RRR_IMM      = 3'd4;

  localparam logic [15:0] PM_NOMOVE   = 16'h2000;
  localparam logic [15:0] PM_UPD_MASK = 16'hFFE0;
  localparam logic [15:0] PM_UPD      = 16'h2040;
  localparam logic [15:0] PM_C1_MASK  = 16'hF040;
  localparam logic [15:0] PM_XC1      = 16'h1000;
  localparam logic [15:0] PM_YC1      = 16'h1040;
  localparam logic [15:0] PM_XC2_MASK = 16'hFEC0;
  localparam logic [15:0] PM_XC2      = 16'h0800;
  localparam logic [15:0] PM_MEM_MASK = 16'hC840;
  localparam logic [15:0] PM_XABS     = 16'h4000;
  localparam logic [15:0] PM_XMEM     = 16'h4040;
  localparam logic [15:0] PM_YMEM     = 16'h4840;
  localparam logic [15:0] PM_RR_MASK  = 16'hFC00;
  localparam logic [15:0] PM_RR       = 16'h2000;
  localparam logic [15:0] PM_IMM_MASK = 16'hE000;
  localparam logic [15:0] PM_IMM      = 16'h2000;

endpackage

// File: hdl/dsp_parallel_move_decoder_unit.sv
// channel  | handshake                   | payload
// request  | in_valid / in_stall         | instr_word, next_word, next_valid
// result   | out_valid / out_stall       | opcode_class .. move1_second
//
// Two register stages: input register, then result register after one pass
// of decode logic. One request per cycle while in_stall is low.
// Synchronous active-high reset clears both valid flags.
// A stalled result holds; in_stall rises only when both stages are full.
module dsp_parallel_move_decoder_unit
  import dpmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] instr_word,
  input  logic [23:0] next_word,
  input  logic        next_valid,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  opcode_class,
  output logic        status,
  output logic [1:0]  words_used,
  output logic [35:0] main_operand_a,
  output logic [35:0] main_operand_b,
  output logic [35:0] move0_first,
  output logic [35:0] move0_second,
  output logic [35:0] move1_first,
  output logic [35:0] move1_second
);

  logic        s_valid;
  logic [23:0] s_instr;
  logic [23:0] s_next;
  logic        s_nvalid;
  logic        out_open;
  logic        s_open;
  result_t     dec;
  result_t     res;

  assign out_open = !out_valid || !out_stall;
  assign s_open   = !s_valid || out_open;
  assign in_stall = !s_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (s_open) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_open && in_valid) begin
      s_instr  <= instr_word;
      s_next   <= next_word;
      s_nvalid <= next_valid;
    end
  end

  dpmd_decode u_decode (
    .instr_word (s_instr),
    .next_word  (s_next),
    .next_valid (s_nvalid),
    .result     (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_open) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open && s_valid) begin
      res <= dec;
    end
  end

  assign opcode_class   = res.opcode_class;
  assign status         = res.status;
  assign words_used     = res.words_used;
  assign main_operand_a = res.main_a;
  assign main_operand_b = res.main_b;
  assign move0_first    = res.m00;
  assign move0_second   = res.m01;
  assign move1_first    = res.m10;
  assign move1_second   = res.m11;

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s_valid && out_valid && out_stall))
    else $error("request stalled with a free stage");

  a_err_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (words_used == WC_ONE && main_operand_a == '0 &&
      main_operand_b == '0 && move0_first == '0 && move0_second == '0 &&
      move1_first == '0 && move1_second == '0))
    else $error("error result carries operands");

  a_ext_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && words_used == WC_TWO) |-> (!status && opcode_class != CLS_INVALID))
    else $error("extension word used by invalid or failed decode");

  a_invalid_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && opcode_class == CLS_INVALID) |->
      (!status && words_used == WC_ONE && move0_first == '0 && main_operand_a == '0))
    else $error("invalid opcode with decoded content");

endmodule

// File: hdl/dpmd_decode.sv
module dpmd_decode
  import dpmd_pkg::*;
(
  input  logic [23:0] instr_word,
  input  logic [23:0] next_word,
  input  logic        next_valid,
  output result_t     result
);

  typedef struct packed {
    operand_t op;
    logic     err;
    logic     used;
  } ea_t;

  function automatic operand_t reg_op(input logic [5:0] r);
    operand_t o;
    o = '0;
    o.kind = T_REG;
    o.regs = r;
    return o;
  endfunction

  function automatic logic [5:0] move_reg5(input logic [4:0] idx);
    logic [5:0] r;
    r = (idx < 5'd4) ? RG_NONE : ({1'b0, idx} - 6'd3);
    return r;
  endfunction

  function automatic ea_t ea_fn(input logic [1:0] sp, input logic [2:0] mmm,
                                input logic [2:0] rrr, input logic [23:0] ext,
                                input logic ext_ok);
    ea_t e;
    e = '0;
    if (mmm != MODE_SPECIAL) begin
      case (mmm)
        3'd0:    e.op.kind = T_PDECN;
        3'd1:    e.op.kind = T_PINCN;
        3'd2:    e.op.kind = T_PDEC;
        3'd3:    e.op.kind = T_PINC;
        3'd4:    e.op.kind = T_NOUPD;
        3'd5:    e.op.kind = T_IDXN;
        default: e.op.kind = T_PREDEC;
      endcase
      e.op.regs  = RG_R0 + {3'b000, rrr};
      e.op.space = sp;
    end else if ((rrr != RRR_ABS && rrr != RRR_IMM) || !ext_ok) begin
      e.err = 1'b1;
    end else begin
      e.used     = 1'b1;
      e.op.value = ext;
      if (rrr == RRR_IMM) begin
        e.op.kind = T_IMM;
      end else begin
        e.op.kind  = T_ABS;
        e.op.space = sp;
      end
    end
    return e;
  endfunction

  logic [7:0]  lo;
  logic [15:0] p;
  logic [1:0]  cls;
  logic        w;
  logic [4:0]  d5;
  ea_t         ea_x;
  ea_t         ea_y;
  ea_t         ea_s;
  operand_t    ma, mb, m00, m01, m10, m11, oa, ob;
  logic        err, used;
  logic [5:0]  acc;

  assign lo   = instr_word[7:0];
  assign p    = instr_word[23:8];
  assign w    = p[7];
  assign d5   = {p[13:12], p[10:8]};
  assign ea_x = ea_fn(SP_X, p[5:3], p[2:0], next_word, next_valid);
  assign ea_y = ea_fn(SP_Y, p[5:3], p[2:0], next_word, next_valid);
  assign ea_s = p[11] ? ea_y : ea_x;

  always_comb begin
    cls  = CLS_INVALID;
    ma   = '0;
    mb   = '0;
    m00  = '0;
    m01  = '0;
    m10  = '0;
    m11  = '0;
    oa   = '0;
    ob   = '0;
    err  = 1'b0;
    used = 1'b0;
    acc  = p[8] ? RG_B : RG_A;
    if (lo == OP_ADC0 || lo == OP_ADC1 || lo == OP_ADC2 || lo == OP_ADC3) begin
      cls = CLS_ADC;
      ma  = reg_op(instr_word[4] ? RG_Y : RG_X);
      mb  = reg_op(instr_word[3] ? RG_B : RG_A);
    end else if (lo == OP_ABS0 || lo == OP_ABS1) begin
      cls = CLS_ABS;
      ma  = reg_op(instr_word[3] ? RG_B : RG_A);
    end
    if (cls != CLS_INVALID) begin
      if (p == PM_NOMOVE) begin
        m00 = '0;
      end else if ((p & PM_UPD_MASK) == PM_UPD) begin
        m00.kind = T_PDECN + {2'b00, p[4:3]};
        m00.regs = RG_R0 + {3'b000, p[2:0]};
      end else if ((p & PM_C1_MASK) == PM_XC1) begin
        case (p[11:10])
          2'd0:    ob = reg_op(RG_X0);
          2'd1:    ob = reg_op(RG_X1);
          2'd2:    ob = reg_op(RG_A);
          default: ob = reg_op(RG_B);
        endcase
        oa   = ea_x.op;
        m00  = w ? oa : ob;
        m01  = w ? ob : oa;
        err  = ea_x.err;
        used = ea_x.used;
        m10  = reg_op(p[9] ? RG_B : RG_A);
        m11  = reg_op(p[8] ? RG_Y1 : RG_Y0);
      end else if ((p & PM_C1_MASK) == PM_YC1) begin
        case (p[9:8])
          2'd0:    ob = reg_op(RG_Y0);
          2'd1:    ob = reg_op(RG_Y1);
          2'd2:    ob = reg_op(RG_A);
          default: ob = reg_op(RG_B);
        endcase
        oa   = ea_y.op;
        m10  = w ? oa : ob;
        m11  = w ? ob : oa;
        err  = ea_y.err;
        used = ea_y.used;
        m00  = reg_op(p[11] ? RG_B : RG_A);
        m01  = reg_op(p[10] ? RG_X1 : RG_X0);
      end else if ((p & PM_XC2_MASK) == PM_XC2) begin
        m00  = reg_op(acc);
        m01  = ea_x.op;
        err  = ea_x.err;
        used = ea_x.used;
        m10  = reg_op(RG_X0);
        m11  = reg_op(acc);
      end else if ((p & PM_MEM_MASK) == PM_XABS) begin
        oa.kind  = T_ABS;
        oa.space = SP_X;
        oa.value = {18'd0, p[5:0]};
        ob       = reg_op(move_reg5(d5));
        m00      = w ? oa : ob;
        m01      = w ? ob : oa;
      end else if ((p & PM_MEM_MASK) == PM_XMEM || (p & PM_MEM_MASK) == PM_YMEM) begin
        ob   = reg_op(move_reg5(d5));
        oa   = ea_s.op;
        err  = ea_s.err;
        used = ea_s.used;
        if (p[11]) begin
          m10 = w ? oa : ob;
          m11 = w ? ob : oa;
        end else begin
          m00 = w ? oa : ob;
          m01 = w ? ob : oa;
        end
      end else if ((p & PM_RR_MASK) == PM_RR) begin
        m00 = reg_op(move_reg5(p[9:5]));
        m01 = reg_op(move_reg5(p[4:0]));
      end else if ((p & PM_IMM_MASK) == PM_IMM) begin
        m00.kind  = T_SIMM;
        m00.value = {16'd0, p[7:0]};
        m01       = reg_op(move_reg5(p[12:8]));
      end
    end
    if (err) begin
      ma   = '0;
      mb   = '0;
      m00  = '0;
      m01  = '0;
      m10  = '0;
      m11  = '0;
      used = 1'b0;
    end
    result.opcode_class = cls;
    result.status       = err;
    result.words_used   = used ? WC_TWO : WC_ONE;
    result.main_a       = ma;
    result.main_b       = mb;
    result.m00          = m00;
    result.m01          = m01;
    result.m10          = m10;
    result.m11          = m11;
  end

endmodule

// File: dv/dpmd_decode_checker.sv
module dpmd_decode_checker
  import dpmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [23:0] instr_word,
  input  logic [23:0] next_word,
  input  logic        next_valid,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  opcode_class,
  input  logic        status,
  input  logic [1:0]  words_used,
  input  logic [35:0] main_operand_a,
  input  logic [35:0] main_operand_b,
  input  logic [35:0] move0_first,
  input  logic [35:0] move0_second,
  input  logic [35:0] move1_first,
  input  logic [35:0] move1_second,
  output int          mismatches,
  output int          awaiting,
  output int          results_seen,
  output int          ext_results,
  output int          error_results
);
  timeunit 1ns;
  timeprecision 1ps;

  result_t pending_decodes[$];

  function automatic operand_t reg_operand(logic [5:0] r);
    operand_t o;
    o = '0;
    o.kind = T_REG;
    o.regs = r;
    return o;
  endfunction

  function automatic logic [5:0] move_register(logic [4:0] idx);
    return (idx < 5'd4) ? RG_NONE : {1'b0, idx} - 6'd3;
  endfunction

  function automatic operand_t addr_operand(logic [3:0] kind, logic [2:0] rrr,
                                            logic [1:0] sp);
    operand_t o;
    o = '0;
    o.kind = kind;
    o.regs = RG_R0 + {3'b000, rrr};
    o.space = sp;
    return o;
  endfunction

  // returns 1 on a bad mode or a missing extension word
  function automatic logic decode_ea(input logic [1:0] sp, input logic [2:0] mmm,
                                     input logic [2:0] rrr, input logic [23:0] ext,
                                     input logic ext_ok, output operand_t o,
                                     inout logic used_ext);
    logic [3:0] kind;
    o = '0;
    if (mmm != MODE_SPECIAL) begin
      case (mmm)
        3'd0: kind = T_PDECN;
        3'd1: kind = T_PINCN;
        3'd2: kind = T_PDEC;
        3'd3: kind = T_PINC;
        3'd4: kind = T_NOUPD;
        3'd5: kind = T_IDXN;
        default: kind = T_PREDEC;
      endcase
      o = addr_operand(kind, rrr, sp);
      return 1'b0;
    end
    if ((rrr != RRR_ABS && rrr != RRR_IMM) || !ext_ok) return 1'b1;
    used_ext = 1'b1;
    o.value = ext;
    if (rrr == RRR_IMM) begin
      o.kind = T_IMM;
    end else begin
      o.kind = T_ABS;
      o.space = sp;
    end
    return 1'b0;
  endfunction

  function automatic result_t predict_decode(logic [23:0] iw, logic [23:0] nw, logic nv);
    result_t  r;
    operand_t mv [2][2];
    operand_t ea, regop;
    logic [15:0] p;
    logic [2:0]  mmm, rrr;
    logic [4:0]  d5;
    logic [5:0]  acc;
    logic        err, used, w, slot, place;
    r = '0;
    mv = '{default: '0};
    ea = '0;
    regop = '0;
    err = 1'b0;
    used = 1'b0;
    place = 1'b0;
    slot = 1'b0;
    p = iw[23:8];
    w = p[7];
    mmm = p[5:3];
    rrr = p[2:0];
    d5 = {p[13:12], p[10:8]};
    case (iw[7:0])
      OP_ADC0, OP_ADC1, OP_ADC2, OP_ADC3: begin
        r.opcode_class = CLS_ADC;
        r.main_a = reg_operand(iw[4] ? RG_Y : RG_X);
        r.main_b = reg_operand(iw[3] ? RG_B : RG_A);
      end
      OP_ABS0, OP_ABS1: begin
        r.opcode_class = CLS_ABS;
        r.main_a = reg_operand(iw[3] ? RG_B : RG_A);
      end
      default: ;
    endcase
    if (r.opcode_class != CLS_INVALID) begin
      if (p == PM_NOMOVE) begin
      end else if ((p & PM_UPD_MASK) == PM_UPD) begin
        mv[0][0] = addr_operand(T_PDECN + {2'b00, p[4:3]}, rrr, SP_NONE);
      end else if ((p & PM_C1_MASK) == PM_XC1) begin
        err = decode_ea(SP_X, mmm, rrr, nw, nv, ea, used);
        case (p[11:10])
          2'd0: regop = reg_operand(RG_X0);
          2'd1: regop = reg_operand(RG_X1);
          2'd2: regop = reg_operand(RG_A);
          default: regop = reg_operand(RG_B);
        endcase
        place = 1'b1;
        slot = 1'b0;
        mv[1][0] = reg_operand(p[9] ? RG_B : RG_A);
        mv[1][1] = reg_operand(p[8] ? RG_Y1 : RG_Y0);
      end else if ((p & PM_C1_MASK) == PM_YC1) begin
        err = decode_ea(SP_Y, mmm, rrr, nw, nv, ea, used);
        case (p[9:8])
          2'd0: regop = reg_operand(RG_Y0);
          2'd1: regop = reg_operand(RG_Y1);
          2'd2: regop = reg_operand(RG_A);
          default: regop = reg_operand(RG_B);
        endcase
        place = 1'b1;
        slot = 1'b1;
        mv[0][0] = reg_operand(p[11] ? RG_B : RG_A);
        mv[0][1] = reg_operand(p[10] ? RG_X1 : RG_X0);
      end else if ((p & PM_XC2_MASK) == PM_XC2) begin
        acc = p[8] ? RG_B : RG_A;
        err = decode_ea(SP_X, mmm, rrr, nw, nv, ea, used);
        mv[0][0] = reg_operand(acc);
        mv[0][1] = ea;
        mv[1][0] = reg_operand(RG_X0);
        mv[1][1] = reg_operand(acc);
      end else if ((p & PM_MEM_MASK) == PM_XABS) begin
        ea.kind = T_ABS;
        ea.space = SP_X;
        ea.value = {18'd0, p[5:0]};
        regop = reg_operand(move_register(d5));
        place = 1'b1;
        slot = 1'b0;
      end else if ((p & PM_MEM_MASK) == PM_XMEM || (p & PM_MEM_MASK) == PM_YMEM) begin
        slot = p[11];
        err = decode_ea(slot ? SP_Y : SP_X, mmm, rrr, nw, nv, ea, used);
        regop = reg_operand(move_register(d5));
        place = 1'b1;
      end else if ((p & PM_RR_MASK) == PM_RR) begin
        mv[0][0] = reg_operand(move_register(p[9:5]));
        mv[0][1] = reg_operand(move_register(p[4:0]));
      end else if ((p & PM_IMM_MASK) == PM_IMM) begin
        mv[0][0].kind = T_SIMM;
        mv[0][0].value = {16'd0, p[7:0]};
        mv[0][1] = reg_operand(move_register(p[12:8]));
      end
      if (place) begin
        mv[slot][!w] = ea;
        mv[slot][w] = regop;
      end
    end
    if (err) begin
      mv = '{default: '0};
      r.main_a = '0;
      r.main_b = '0;
      used = 1'b0;
    end
    r.status = err;
    r.words_used = used ? WC_TWO : WC_ONE;
    r.m00 = mv[0][0];
    r.m01 = mv[0][1];
    r.m10 = mv[1][0];
    r.m11 = mv[1][1];
    return r;
  endfunction

  task automatic check_field(input string field, input logic [35:0] want_v,
                             input logic [35:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %h, got %h", $time, field, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      mismatches = 0;
      results_seen = 0;
      ext_results = 0;
      error_results = 0;
      pending_decodes.delete();
    end else begin
      if (in_valid && !in_stall)
        pending_decodes.push_back(predict_decode(instr_word, next_word, next_valid));
      if (out_valid && !out_stall) begin
        if (pending_decodes.size() == 0) begin
          $display("%0t: result with no request pending", $time);
          mismatches++;
        end else begin
          want = pending_decodes.pop_front();
          check_field("opcode_class", 36'(want.opcode_class), 36'(opcode_class));
          check_field("status", 36'(want.status), 36'(status));
          check_field("words_used", 36'(want.words_used), 36'(words_used));
          check_field("main_operand_a", want.main_a, main_operand_a);
          check_field("main_operand_b", want.main_b, main_operand_b);
          check_field("move0_first", want.m00, move0_first);
          check_field("move0_second", want.m01, move0_second);
          check_field("move1_first", want.m10, move1_first);
          check_field("move1_second", want.m11, move1_second);
          results_seen++;
          if (want.words_used == WC_TWO) ext_results++;
          if (want.status) error_results++;
        end
      end
    end
    awaiting = pending_decodes.size();
  end

endmodule

// File: dv/dsp_parallel_move_decoder_unit_test.sv
module dsp_parallel_move_decoder_unit_test
  import dpmd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 620;
  localparam int WATCHDOG_LIMIT = 1000;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [23:0] instr_word = '0;
  logic [23:0] next_word = '0;
  logic        next_valid = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  opcode_class;
  logic        status;
  logic [1:0]  words_used;
  logic [35:0] main_operand_a;
  logic [35:0] main_operand_b;
  logic [35:0] move0_first;
  logic [35:0] move0_second;
  logic [35:0] move1_first;
  logic [35:0] move1_second;
  int          mismatches;
  int          awaiting;
  int          results_seen;
  int          ext_results;
  int          error_results;

  dsp_parallel_move_decoder_unit DUT (.*);

  dpmd_decode_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [23:0] random_instruction();
    logic [15:0] p;
    logic [7:0]  lo;
    logic        ea_field;
    p = 16'($urandom);
    lo = 8'($urandom);
    ea_field = 1'b1;
    case ($urandom_range(0, 10))
      0: begin
        p = PM_NOMOVE;
        ea_field = 1'b0;
      end
      1: begin
        p = PM_UPD | (p & ~PM_UPD_MASK);
        ea_field = 1'b0;
      end
      2: p = PM_XC1 | (p & ~PM_C1_MASK);
      3: p = PM_YC1 | (p & ~PM_C1_MASK);
      4: p = PM_XC2 | (p & ~PM_XC2_MASK);
      5: begin
        p = PM_XABS | (p & ~PM_MEM_MASK);
        ea_field = 1'b0;
      end
      6: p = PM_XMEM | (p & ~PM_MEM_MASK);
      7: p = PM_YMEM | (p & ~PM_MEM_MASK);
      8: begin
        p = PM_RR | (p & ~PM_RR_MASK);
        ea_field = 1'b0;
      end
      9: begin
        p = PM_IMM | (p & ~PM_IMM_MASK);
        ea_field = 1'b0;
      end
      default: ;
    endcase
    if (ea_field && $urandom_range(0, 2) == 0) begin
      p[5:3] = MODE_SPECIAL;
      case ($urandom_range(0, 2))
        0: p[2:0] = RRR_ABS;
        1: p[2:0] = RRR_IMM;
        default: ;
      endcase
    end
    case ($urandom_range(0, 7))
      0: lo = OP_ADC0;
      1: lo = OP_ADC1;
      2: lo = OP_ADC2;
      3: lo = OP_ADC3;
      4: lo = OP_ABS0;
      5: lo = OP_ABS1;
      default: ;
    endcase
    return {p, lo};
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [23:0] iw, input logic [23:0] nw,
                              input logic nv);
    in_valid <= 1'b1;
    instr_word <= iw;
    next_word <= nw;
    next_valid <= nv;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  initial begin : result_stall
    int span, pct;
    forever begin
      span = $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 25;
        2: pct = 50;
        default: pct = 85;
      endcase
      repeat (span) begin
        @(negedge clk);
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("dsp_parallel_move_decoder_unit: mismatch");
    $finish;
  end

  initial begin : stimulus
    int  sent, burst, gap;
    logic drained;
    sent = 0;
    drained = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_request(24'h000000, 24'h000000, 1'b0);
    send_request(24'hFFFFFF, 24'hFFFFFF, 1'b1);
    send_request({PM_NOMOVE, OP_ADC0}, 24'h000000, 1'b1);
    send_request({16'h205F, OP_ABS0}, 24'h000000, 1'b1);
    send_request({16'h2040, OP_ADC1}, 24'hFFFFFF, 1'b1);
    send_request({16'h10B0, OP_ADC2}, 24'hFFFFFF, 1'b1);
    send_request({16'h1F74, OP_ABS1}, 24'h123456, 1'b1);
    send_request({16'h0830, OP_ABS0}, 24'hABCDEF, 1'b0);
    send_request({16'h4071, OP_ADC3}, 24'h000000, 1'b1);
    send_request({16'h7FF0, OP_ADC0}, 24'h800001, 1'b1);
    send_request({16'h77BF, OP_ABS1}, 24'h000000, 1'b0);
    send_request({16'h2003, OP_ADC1}, 24'h000000, 1'b0);
    send_request({16'h23FF, OP_ADC2}, 24'h000000, 1'b0);
    send_request({16'h3F80, OP_ABS1}, 24'h000000, 1'b0);
    send_request({16'h2E7F, OP_ABS0}, 24'h000000, 1'b0);
    send_request({16'h4800, OP_ADC3}, 24'hFFFFFF, 1'b1);
    send_request({16'hFFFF, OP_ABS0}, 24'h000000, 1'b0);
    send_request({16'h4874, OP_ADC1}, 24'h000000, 1'b1);
    send_request({16'h407F, OP_ADC2}, 24'hFFFFFF, 1'b1);
    send_request({16'h1FB4, OP_ADC3}, 24'h5A5A5A, 1'b0);
    send_request({16'h1375, OP_ABS1}, 24'h5A5A5A, 1'b1);
    send_request({16'h0930, OP_ADC0}, 24'h000001, 1'b1);
    send_request({16'h10B0, 8'h20}, 24'hA5A5A5, 1'b1);
    send_request({16'h4068, OP_ADC1}, 24'h000000, 1'b1);

    while (sent < RANDOM_REQUESTS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RANDOM_REQUESTS; k++) begin
        send_request(random_instruction(), 24'($urandom), $urandom_range(0, 7) != 0);
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (!drained && sent >= RANDOM_REQUESTS / 2) begin
        // hold until the pipeline is empty
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(negedge clk); while (awaiting != 0);
      end else if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b0;

    while (awaiting != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Checked %0d decoded requests: %0d took an extension word, %0d were rejected",
             results_seen, ext_results, error_results);
    $display("Input sent in bursts with gaps, results stalled in phases, one full drain");
    if (mismatches == 0 && awaiting == 0) begin
      $display("dsp_parallel_move_decoder_unit: match");
    end else begin
      $display("dsp_parallel_move_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/dpmd_pkg.sv
hdl/dpmd_decode.sv
hdl/dsp_parallel_move_decoder_unit.sv
dv/dpmd_decode_checker.sv
dv/dsp_parallel_move_decoder_unit_test.sv
